@@ rtl/bcr_pkg.sv @@
// ----------------------------------------------------------------------------
// bcr_pkg
// shared constants and types for the block cache replacement engine
// ----------------------------------------------------------------------------
package bcr_pkg;

  localparam int unsigned NUM_SLOTS = 16;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned BLK_W     = 32;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned TOT_W     = 32;
  localparam int unsigned SEC_W     = 5;
  localparam int unsigned POL_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // replacement policy codes
  localparam logic [POL_W-1:0] POL_LRU = 2'd0;
  localparam logic [POL_W-1:0] POL_LFU = 2'd1;
  localparam logic [POL_W-1:0] POL_FBR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_SEC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_SEC = 2'd2;

  localparam logic [SEC_W-1:0] SEC_RESET = 5'd4;
  localparam logic [SEC_W-1:0] SEC_FULL  = SEC_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [TOT_W-1:0] TOT_MAX   = '1;
  localparam logic [SLOT_W-1:0] RANK_LAST = SLOT_W'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [BLK_W-1:0] block;
    logic [CNT_W-1:0] count;
  } slot_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } mem_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] rank;
  } rank_upd_t;

endpackage

@@ rtl/bcr_slot_mem.sv @@
// ----------------------------------------------------------------------------
// bcr_slot_mem
// slot storage: tag, block number and use count, one read and one write port
// ----------------------------------------------------------------------------
module bcr_slot_mem (
  input  logic                 clk_i,
  input  bcr_pkg::mem_req_t    req_i,
  output bcr_pkg::slot_entry_t rd_data_o
);
  import bcr_pkg::*;

  slot_entry_t mem_q [NUM_SLOTS];
  slot_entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/bcr_rank_table.sv @@
// ----------------------------------------------------------------------------
// bcr_rank_table
// recency ranks and valid bits per slot, registered move-to-front update
// ----------------------------------------------------------------------------
module bcr_rank_table (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bcr_pkg::rank_upd_t         upd_i,
  input  logic [bcr_pkg::SLOT_W-1:0] idx_i,
  output logic [bcr_pkg::SLOT_W-1:0] rank_o,
  output logic                       valid_o
);
  import bcr_pkg::*;

  logic [SLOT_W-1:0]    rank_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rank_q[i] <= SLOT_W'(i);
      end
      vld_q <= '0;
    end else if (upd_i.en) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (SLOT_W'(i) == upd_i.slot) begin
          rank_q[i] <= '0;
        end else if (rank_q[i] < upd_i.rank) begin
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
      vld_q[upd_i.slot] <= 1'b1;
    end
  end

  assign rank_o  = rank_q[idx_i];
  assign valid_o = vld_q[idx_i];

endmodule

@@ rtl/bcr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcr_ctrl
// access sequencer: slot scan, victim choice, write-back and result register
// ----------------------------------------------------------------------------
module bcr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [bcr_pkg::TAG_W-1:0]   file_tag_i,
  input  logic [bcr_pkg::BLK_W-1:0]   block_in_file_i,
  input  logic [bcr_pkg::POL_W-1:0]   policy_i,
  input  logic [bcr_pkg::SEC_W-1:0]   new_sec_i,
  input  logic [bcr_pkg::SEC_W-1:0]   old_sec_i,
  output bcr_pkg::mem_req_t           mem_req_o,
  input  bcr_pkg::slot_entry_t        mem_rd_data_i,
  output logic [bcr_pkg::SLOT_W-1:0]  rank_idx_o,
  input  logic [bcr_pkg::SLOT_W-1:0]  rank_i,
  input  logic                        slot_valid_i,
  output bcr_pkg::rank_upd_t          rank_upd_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        hit_o,
  output logic [bcr_pkg::SLOT_W-1:0]  slot_o,
  output logic                        evicted_o,
  output logic [bcr_pkg::TOT_W-1:0]   hit_total_o,
  output logic [bcr_pkg::TOT_W-1:0]   miss_total_o
);
  import bcr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [TAG_W-1:0]  tag_q;
  logic [BLK_W-1:0]  blk_q;
  logic [SLOT_W:0]   iss_q, iss_d;
  logic              chk_v_q;
  logic [SLOT_W-1:0] chk_idx_q;

  // scan results
  logic              hit_f_q, empty_f_q, fbr_f_q;
  logic [SLOT_W-1:0] hit_slot_q, hit_rank_q;
  logic [CNT_W-1:0]  hit_cnt_q;
  logic [SLOT_W-1:0] empty_slot_q, empty_rank_q;
  logic [SLOT_W-1:0] lfu_slot_q, lfu_rank_q;
  logic [CNT_W-1:0]  lfu_cnt_q;
  logic [SLOT_W-1:0] fbr_slot_q, fbr_rank_q;
  logic [CNT_W-1:0]  fbr_cnt_q;
  logic [SLOT_W-1:0] lru_slot_q;

  logic [TOT_W-1:0]  hits_q, misses_q;
  logic              out_valid_q, out_hit_q, out_evict_q;
  logic [SLOT_W-1:0] out_slot_q;

  logic              accept, rd_en, scan_last, commit;
  logic [SEC_W-1:0]  old_clamp, fbr_lim;
  logic              fbr_elig, fbr_better, is_match;

  logic              c_hit, c_evict, c_bump;
  logic [SLOT_W-1:0] c_slot, c_rank;
  logic [CNT_W-1:0]  c_cnt;

  assign accept    = (state_q == ST_IDLE) && in_valid_i;
  assign rd_en     = (state_q == ST_SCAN) && !iss_q[SLOT_W];
  assign scan_last = (state_q == ST_SCAN) && chk_v_q && (chk_idx_q == RANK_LAST);
  assign commit    = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // old section clamped to 1..NUM_SLOTS, victims have rank at or above lim
  always_comb begin
    old_clamp = old_sec_i;
    if (old_sec_i == '0) begin
      old_clamp = SEC_W'(1);
    end else if (old_sec_i > SEC_FULL) begin
      old_clamp = SEC_FULL;
    end
  end
  assign fbr_lim  = SEC_FULL - old_clamp;
  assign fbr_elig = {1'b0, rank_i} >= fbr_lim;
  assign fbr_better = !fbr_f_q || (mem_rd_data_i.count < fbr_cnt_q) ||
                      ((mem_rd_data_i.count == fbr_cnt_q) && (rank_i > fbr_rank_q));
  assign is_match = slot_valid_i && (mem_rd_data_i.tag == tag_q) &&
                    (mem_rd_data_i.block == blk_q);

  always_comb begin
    state_d = state_q;
    iss_d   = iss_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
          iss_d   = '0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          iss_d = iss_q + 1'b1;
        end
        if (scan_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // final decision for the access
  always_comb begin
    c_hit   = hit_f_q;
    c_evict = 1'b0;
    c_bump  = 1'b0;
    c_cnt   = CNT_W'(1);
    if (hit_f_q) begin
      c_slot = hit_slot_q;
      c_rank = hit_rank_q;
      c_bump = (policy_i == POL_FBR) ? ({1'b0, hit_rank_q} >= new_sec_i) : 1'b1;
      c_cnt  = (c_bump && (hit_cnt_q != CNT_MAX)) ? hit_cnt_q + 1'b1 : hit_cnt_q;
    end else if (empty_f_q) begin
      c_slot = empty_slot_q;
      c_rank = empty_rank_q;
    end else begin
      c_evict = 1'b1;
      if (policy_i == POL_LFU) begin
        c_slot = lfu_slot_q;
        c_rank = lfu_rank_q;
      end else if (policy_i == POL_FBR) begin
        c_slot = fbr_slot_q;
        c_rank = fbr_rank_q;
      end else begin
        c_slot = lru_slot_q;
        c_rank = RANK_LAST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iss_q       <= '0;
      chk_v_q     <= 1'b0;
      hit_f_q     <= 1'b0;
      empty_f_q   <= 1'b0;
      fbr_f_q     <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      chk_v_q <= rd_en;
      if (accept) begin
        hit_f_q   <= 1'b0;
        empty_f_q <= 1'b0;
        fbr_f_q   <= 1'b0;
      end else if (chk_v_q) begin
        if (is_match && !hit_f_q) begin
          hit_f_q <= 1'b1;
        end
        if (!slot_valid_i && !empty_f_q) begin
          empty_f_q <= 1'b1;
        end
        if (fbr_elig && fbr_better) begin
          fbr_f_q <= 1'b1;
        end
      end
      if (commit) begin
        if (c_hit) begin
          if (hits_q != TOT_MAX) begin
            hits_q <= hits_q + 1'b1;
          end
        end else if (misses_q != TOT_MAX) begin
          misses_q <= misses_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload side of the scan, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tag_q <= file_tag_i;
      blk_q <= block_in_file_i;
    end
    chk_idx_q <= iss_q[SLOT_W-1:0];
    if (chk_v_q) begin
      if (is_match && !hit_f_q) begin
        hit_slot_q <= chk_idx_q;
        hit_rank_q <= rank_i;
        hit_cnt_q  <= mem_rd_data_i.count;
      end
      if (!slot_valid_i && !empty_f_q) begin
        empty_slot_q <= chk_idx_q;
        empty_rank_q <= rank_i;
      end
      if ((chk_idx_q == '0) || (mem_rd_data_i.count < lfu_cnt_q)) begin
        lfu_slot_q <= chk_idx_q;
        lfu_rank_q <= rank_i;
        lfu_cnt_q  <= mem_rd_data_i.count;
      end
      if (fbr_elig && fbr_better) begin
        fbr_slot_q <= chk_idx_q;
        fbr_rank_q <= rank_i;
        fbr_cnt_q  <= mem_rd_data_i.count;
      end
      if (rank_i == RANK_LAST) begin
        lru_slot_q <= chk_idx_q;
      end
    end
    if (commit) begin
      out_hit_q   <= c_hit;
      out_slot_q  <= c_slot;
      out_evict_q <= c_evict;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign rank_idx_o = chk_idx_q;

  assign mem_req_o.rd_en         = rd_en;
  assign mem_req_o.rd_addr       = iss_q[SLOT_W-1:0];
  assign mem_req_o.wr_en         = commit;
  assign mem_req_o.wr_addr       = c_slot;
  assign mem_req_o.wr_data.tag   = tag_q;
  assign mem_req_o.wr_data.block = blk_q;
  assign mem_req_o.wr_data.count = c_cnt;

  assign rank_upd_o.en   = commit;
  assign rank_upd_o.slot = c_slot;
  assign rank_upd_o.rank = c_rank;

  assign out_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign slot_o       = out_slot_q;
  assign evicted_o    = out_evict_q;
  // totals only move at commit, which waits for the result register to drain
  assign hit_total_o  = hits_q;
  assign miss_total_o = misses_q;

endmodule

@@ rtl/block_cache_replacement.sv @@
// sequence: an input transaction is taken in idle, then the 16-entry scan of the
//   single-read-port slot memory with registered read data, then the commit
//   state, which waits for the result register to drain; no new input is taken
//   until the previous access has committed and the block is back in idle
// reset: all slots empty, recency ranks equal slot index, totals zero,
//   policy LRU, new and old section sizes 4; no clearing pass
// ----------------------------------------------------------------------------
// block_cache_replacement
// block cache slot lookup with LRU, LFU and FBR victim selection
// ----------------------------------------------------------------------------
module block_cache_replacement (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bcr_pkg::TAG_W-1:0]      file_tag_i,
  input  logic [bcr_pkg::BLK_W-1:0]      block_in_file_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [bcr_pkg::SLOT_W-1:0]     slot_o,
  output logic                           evicted_o,
  output logic [bcr_pkg::TOT_W-1:0]      hit_total_o,
  output logic [bcr_pkg::TOT_W-1:0]      miss_total_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bcr_pkg::SEC_W-1:0]      cfg_data_i
);
  import bcr_pkg::*;

  logic [POL_W-1:0] policy_q;
  logic [SEC_W-1:0] new_sec_q, old_sec_q;

  mem_req_t          mem_req;
  slot_entry_t       mem_rd_data;
  rank_upd_t         rank_upd;
  logic [SLOT_W-1:0] rank_idx, rank;
  logic              slot_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_LRU;
      new_sec_q <= SEC_RESET;
      old_sec_q <= SEC_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POLICY:  policy_q  <= cfg_data_i[POL_W-1:0];
        CFG_NEW_SEC: new_sec_q <= cfg_data_i;
        CFG_OLD_SEC: old_sec_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcr_slot_mem u_slot_mem (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (mem_rd_data)
  );

  bcr_rank_table u_rank_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (rank_upd),
    .idx_i   (rank_idx),
    .rank_o  (rank),
    .valid_o (slot_valid)
  );

  bcr_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .file_tag_i      (file_tag_i),
    .block_in_file_i (block_in_file_i),
    .policy_i        (policy_q),
    .new_sec_i       (new_sec_q),
    .old_sec_i       (old_sec_q),
    .mem_req_o       (mem_req),
    .mem_rd_data_i   (mem_rd_data),
    .rank_idx_o      (rank_idx),
    .rank_i          (rank),
    .slot_valid_i    (slot_valid),
    .rank_upd_o      (rank_upd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_o       (evicted_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o)
  );

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the block cache replacement engine: block accesses
// go in over a valid/ready channel and every result is checked against the
// directed table or a slot, recency and count tracker kept here. LRU, LFU
// and FBR are covered under varied section sizes and backpressure.
// ----------------------------------------------------------------------------
module testbench;
  import bcr_pkg::*;

  localparam logic [POL_W-1:0]     POL_SPARE       = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED      = 2'd3;
  localparam int                   NUM_PHASES      = 9;
  localparam int                   ITEMS_PER_PHASE = 75;
  localparam int                   POOL_DEPTH      = 24;
  localparam int                   HOLD_OFF_CYCLES = 400;
  localparam int                   SETTLE_CYCLES   = 40;
  localparam int                   WATCHDOG_LIMIT  = 5000;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [TOT_W-1:0]  hits;
    logic [TOT_W-1:0]  misses;
  } access_result_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [BLK_W-1:0] blk;
    logic             typed;
    access_result_t   res;
  } directed_row_t;

  typedef struct packed {
    logic [POL_W-1:0] pol;
    logic [SEC_W-1:0] new_sec;
    logic [SEC_W-1:0] old_sec;
  } reg_setting_t;

  // first rows fill the cache from empty, the last ones run into replacement
  localparam directed_row_t DIRECTED [21] = '{
    '{16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 4'd0,  1'b0, 32'd0, 32'd1}},
    '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd1,  1'b0, 32'd0, 32'd2}},
    '{16'h0000, 32'h0000_0000, 1'b1, '{1'b1, 4'd0,  1'b0, 32'd1, 32'd2}},
    '{16'hFFFF, 32'h0000_0000, 1'b1, '{1'b0, 4'd2,  1'b0, 32'd1, 32'd3}},
    '{16'h0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 4'd3,  1'b0, 32'd1, 32'd4}},
    '{16'h8000, 32'h8000_0000, 1'b1, '{1'b0, 4'd4,  1'b0, 32'd1, 32'd5}},
    '{16'h0001, 32'h0000_0001, 1'b1, '{1'b0, 4'd5,  1'b0, 32'd1, 32'd6}},
    '{16'h5555, 32'h5555_5555, 1'b1, '{1'b0, 4'd6,  1'b0, 32'd1, 32'd7}},
    '{16'hAAAA, 32'hAAAA_AAAA, 1'b1, '{1'b0, 4'd7,  1'b0, 32'd1, 32'd8}},
    '{16'h0000, 32'h0000_0001, 1'b1, '{1'b0, 4'd8,  1'b0, 32'd1, 32'd9}},
    '{16'h0001, 32'h0000_0000, 1'b1, '{1'b0, 4'd9,  1'b0, 32'd1, 32'd10}},
    '{16'h1234, 32'h89AB_CDEF, 1'b1, '{1'b0, 4'd10, 1'b0, 32'd1, 32'd11}},
    '{16'hFFFE, 32'h7FFF_FFFF, 1'b1, '{1'b0, 4'd11, 1'b0, 32'd1, 32'd12}},
    '{16'h7FFF, 32'hFFFF_FFFE, 1'b1, '{1'b0, 4'd12, 1'b0, 32'd1, 32'd13}},
    '{16'h00FF, 32'h00FF_00FF, 1'b1, '{1'b0, 4'd13, 1'b0, 32'd1, 32'd14}},
    '{16'hFF00, 32'hFF00_FF00, 1'b1, '{1'b0, 4'd14, 1'b0, 32'd1, 32'd15}},
    '{16'h0F0F, 32'h0F0F_0F0F, 1'b1, '{1'b0, 4'd15, 1'b0, 32'd1, 32'd16}},
    '{16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1,  1'b0, 32'd2, 32'd16}},
    '{16'hC0DE, 32'h0000_BEEF, 1'b0, '0},
    '{16'h0000, 32'h0000_0000, 1'b0, '0},
    '{16'hC0DE, 32'h0000_BEEF, 1'b0, '0}
  };

  // unused policy code, zero and oversized sections, new section past the end
  localparam reg_setting_t SETTINGS_TABLE [NUM_PHASES] = '{
    '{POL_LFU,   5'd4,  5'd4},
    '{POL_FBR,   5'd4,  5'd4},
    '{POL_FBR,   5'd0,  5'd1},
    '{POL_FBR,   5'd16, 5'd16},
    '{POL_FBR,   5'd31, 5'd0},
    '{POL_FBR,   5'd2,  5'd31},
    '{POL_SPARE, 5'd8,  5'd8},
    '{POL_LRU,   5'd0,  5'd0},
    '{POL_FBR,   5'd6,  5'd10}
  };

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_ready_o;
  logic [TAG_W-1:0]     file_tag_i      = '0;
  logic [BLK_W-1:0]     block_in_file_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i     = 1'b0;
  logic                 hit_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 evicted_o;
  logic [TOT_W-1:0]     hit_total_o;
  logic [TOT_W-1:0]     miss_total_o;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [SEC_W-1:0]     cfg_data_i      = '0;

  // tracked cache contents
  logic [POL_W-1:0]  pol_q      = POL_LRU;
  logic [SEC_W-1:0]  new_sec_q  = SEC_RESET;
  logic [SEC_W-1:0]  old_sec_q  = SEC_RESET;
  logic              slot_used  [NUM_SLOTS];
  logic [TAG_W-1:0]  slot_tag   [NUM_SLOTS];
  logic [BLK_W-1:0]  slot_blk   [NUM_SLOTS];
  logic [CNT_W-1:0]  slot_cnt   [NUM_SLOTS];
  logic [SLOT_W-1:0] slot_rank  [NUM_SLOTS];
  logic [TOT_W-1:0]  hit_cnt    = '0;
  logic [TOT_W-1:0]  miss_cnt   = '0;

  access_result_t expected_q[$];
  int             fault_count     = 0;
  int             tx_idle_pct     = 0;
  int             rx_idle_pct     = 0;
  logic           rx_hold_request = 1'b0;
  int             rx_hold_left    = 0;
  int             quiet_cycles    = 0;

  block_cache_replacement uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_tag[i]  = '0;
      slot_blk[i]  = '0;
      slot_cnt[i]  = '0;
      slot_rank[i] = SLOT_W'(i);
    end
  end

  function automatic access_result_t predict_access(input logic [TAG_W-1:0] tag,
                                                    input logic [BLK_W-1:0] blk);
    access_result_t    res;
    int                s;
    int                olds;
    int                lim;
    bit                found;
    bit                have;
    logic [SLOT_W-1:0] r;
    res   = '0;
    s     = 0;
    found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!found && slot_used[i] && slot_tag[i] == tag && slot_blk[i] == blk) begin
        s     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      // in FBR a hit inside the new section leaves the count alone
      if ((pol_q != POL_FBR || {1'b0, slot_rank[s]} >= new_sec_q) && slot_cnt[s] != CNT_MAX)
        slot_cnt[s] = slot_cnt[s] + 1'b1;
      if (hit_cnt != TOT_MAX) hit_cnt = hit_cnt + 1'b1;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!found && !slot_used[i]) begin
          s     = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.evicted = 1'b1;
        case (pol_q)
          POL_LFU: begin
            s = 0;
            for (int i = 1; i < NUM_SLOTS; i++)
              if (slot_cnt[i] < slot_cnt[s]) s = i;
          end
          POL_FBR: begin
            olds = (old_sec_q == 0) ? 1 : ((old_sec_q > NUM_SLOTS) ? NUM_SLOTS : old_sec_q);
            lim  = NUM_SLOTS - olds;
            s    = 0;
            have = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (slot_rank[i] >= lim && (!have || slot_cnt[i] < slot_cnt[s] ||
                  (slot_cnt[i] == slot_cnt[s] && slot_rank[i] > slot_rank[s]))) begin
                s    = i;
                have = 1'b1;
              end
            end
          end
          default: begin
            for (int i = 0; i < NUM_SLOTS; i++)
              if (slot_rank[i] == RANK_LAST) s = i;
          end
        endcase
      end
      slot_used[s] = 1'b1;
      slot_tag[s]  = tag;
      slot_blk[s]  = blk;
      slot_cnt[s]  = CNT_W'(1);
      if (miss_cnt != TOT_MAX) miss_cnt = miss_cnt + 1'b1;
    end
    r = slot_rank[s];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_rank[i] < r) slot_rank[i] = slot_rank[i] + 1'b1;
    slot_rank[s] = '0;
    res.slot     = SLOT_W'(s);
    res.hits     = hit_cnt;
    res.misses   = miss_cnt;
    return res;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_access(input logic [TAG_W-1:0] tag, input logic [BLK_W-1:0] blk,
                             input logic typed, input access_result_t typed_res);
    access_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    file_tag_i      <= tag;
    block_in_file_i <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    res = predict_access(tag, blk);
    expected_q.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEC_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_POLICY:  pol_q     = val[POL_W-1:0];
      CFG_NEW_SEC: new_sec_q = val;
      CFG_OLD_SEC: old_sec_q = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // always advances to a later falling edge so valid is never lowered and raised in one step
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_q.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (rx_hold_request) begin
      rx_hold_left    = HOLD_OFF_CYCLES;
      rx_hold_request <= 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        fault_count++;
        $display("%0t: unexpected result transaction hit=%0b slot=%0d", $time, hit_o, slot_o);
      end else begin
        want = expected_q.pop_front();
        if (hit_o !== want.hit || slot_o !== want.slot || evicted_o !== want.evicted ||
            hit_total_o !== want.hits || miss_total_o !== want.misses) begin
          fault_count++;
          $display("%0t: mismatch expected hit=%0b slot=%0d evicted=%0b hits=%0d misses=%0d",
                   $time, want.hit, want.slot, want.evicted, want.hits, want.misses);
          $display("%0t:          actual hit=%0b slot=%0d evicted=%0b hits=%0d misses=%0d",
                   $time, hit_o, slot_o, evicted_o, hit_total_o, miss_total_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [TAG_W-1:0] pool_tag [POOL_DEPTH];
    logic [BLK_W-1:0] pool_blk [POOL_DEPTH];
    int               pool_size;
    int               mode;
    int               k;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 21;
    rx_idle_pct <= 84;
    foreach (DIRECTED[i])
      send_access(DIRECTED[i].tag, DIRECTED[i].blk, DIRECTED[i].typed, DIRECTED[i].res);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_POLICY, SEC_W'(SETTINGS_TABLE[p].pol));
      write_reg(CFG_NEW_SEC, SETTINGS_TABLE[p].new_sec);
      write_reg(CFG_OLD_SEC, SETTINGS_TABLE[p].old_sec);
      if (p == 0) write_reg(CFG_UNUSED, 5'h1F);
      cfg_valid_i <= 1'b0;

      // sender-light, receiver-light, then no idling at all
      mode        = p * 3 / NUM_PHASES;
      tx_idle_pct = (mode == 0) ? 21 : ((mode == 1) ? 84 : 0);
      rx_idle_pct <= (mode == 0) ? 84 : ((mode == 1) ? 21 : 0);

      // working set of 12 to 24 entries around the 16-slot cache, pairs of adjacent blocks per file
      pool_size = $urandom_range(24, 12);
      for (int i = 0; i < pool_size; i++) begin
        if (i % 2 == 1) begin
          pool_tag[i] = pool_tag[i-1];
          pool_blk[i] = pool_blk[i-1] + 1;
        end else begin
          pool_tag[i] = TAG_W'($urandom);
          pool_blk[i] = $urandom;
        end
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 80) begin
          // skewed toward low entries so use counts spread apart
          k = $urandom_range($urandom_range(pool_size - 1, 0), 0);
          send_access(pool_tag[k], pool_blk[k], 1'b0, '0);
        end else begin
          send_access(TAG_W'($urandom), $urandom, 1'b0, '0);
        end
        if (p == 0 && n == 30) rx_hold_request <= 1'b1;
        if (p == 4 && n == 40) drain_results();
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      fault_count++;
      $display("%0t: %0d results never arrived", $time, expected_q.size());
    end
    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
